// ----- hdl/xs128_pkg.sv -----
// Shared types, constants and functions for the xorshift128 generator.
package xs128_pkg;

    localparam logic [31:0] SEED_MULT  = 32'd1812433253;
    localparam logic [31:0] SEED_XOR_A = 32'd123464980;
    localparam logic [31:0] SEED_XOR_B = 32'd3447902351;
    localparam logic [31:0] SEED_XOR_C = 32'd2859490775;
    localparam logic [31:0] SEED_XOR_D = 32'd47621719;
    localparam logic [31:0] RESET_A    = 32'd123456789;
    localparam logic [31:0] RESET_B    = 32'd362436069;
    localparam logic [31:0] RESET_C    = 32'd521288629;
    localparam logic [31:0] RESET_D    = 32'd88675123;

    localparam int unsigned SEED_PASSES = 8;
    localparam int unsigned PASS_W      = $clog2(SEED_PASSES);

    localparam logic OP_SEED = 1'b0;
    localparam logic OP_NEXT = 1'b1;

    typedef enum logic [1:0] {
        WORD_A = 2'd0,
        WORD_B = 2'd1,
        WORD_C = 2'd2,
        WORD_D = 2'd3
    } word_sel_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_MUL  = 2'd1,
        ST_MIX  = 2'd2
    } state_t;

    typedef struct packed {
        logic      load_seed;
        logic      advance;
        logic      mul;
        logic      mix;
        word_sel_t word_sel;
        logic      load_reset;
    } dp_cmd_t;

    typedef struct packed {
        logic all_zero;
    } dp_status_t;

    function automatic logic [31:0] seed_xor(input word_sel_t sel);
        logic [31:0] k;
        case (sel)
            WORD_A:  k = SEED_XOR_A;
            WORD_B:  k = SEED_XOR_B;
            WORD_C:  k = SEED_XOR_C;
            WORD_D:  k = SEED_XOR_D;
            default: k = SEED_XOR_A;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] seed_shift(input logic [31:0] p);
        logic [31:0] x;
        x = p ^ (p << 13);
        return x ^ (x >> 17);
    endfunction

endpackage

// ----- hdl/xorshift128_generator_with_seeding_unit.sv -----
// Top level: xorshift128 generator with seed mixing.
// Next item: result registered the cycle after acceptance; one item per cycle while
// the output is not stalled. Seed item: each round multiplies, then mixes and loads,
// four rounds per pass, up to 8 passes while all words are zero.
// Reset loads the standard xorshift128 constants; no output is pending after reset.
module xorshift128_generator_with_seeding_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [31:0] s_seed_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_random_word
);

    xs128_pkg::dp_cmd_t    cmd;
    xs128_pkg::dp_status_t status;

    xs128_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_op),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    xs128_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .seed_in     (s_seed_value),
        .status      (status),
        .random_word (m_random_word)
    );

    a_seed_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_op == xs128_pkg::OP_SEED) |=> !s_ready)
        else $error("input accepted during seeding");

    a_next_gives_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_op == xs128_pkg::OP_NEXT) |=> m_valid)
        else $error("next item produced no result");

    a_mul_then_mix: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul |=> cmd.mix)
        else $error("multiply not followed by mix");

    a_no_advance_while_seeding: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.mul || cmd.mix) |-> !cmd.advance)
        else $error("advance during seeding");

endmodule

// ----- hdl/xs128_datapath.sv -----
// Datapath: state words, seed multiply and mix, xorshift step and output register.
module xs128_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  xs128_pkg::dp_cmd_t    cmd,
    input  logic [31:0]           seed_in,
    output xs128_pkg::dp_status_t status,
    output logic [31:0]           random_word
);

    logic [31:0] word_a_reg, word_a_next;
    logic [31:0] word_b_reg, word_b_next;
    logic [31:0] word_c_reg, word_c_next;
    logic [31:0] word_d_reg, word_d_next;
    logic [31:0] seed_reg, seed_next;
    logic [31:0] prod_reg, prod_next;
    logic [31:0] out_reg, out_next;
    logic [31:0] mixed;
    logic [31:0] loaded;
    logic [31:0] t;
    logic [31:0] step_d;

    assign mixed  = xs128_pkg::seed_shift(prod_reg);
    assign loaded = mixed ^ xs128_pkg::seed_xor(cmd.word_sel);
    assign t      = word_a_reg ^ (word_a_reg << 11);
    assign step_d = word_d_reg ^ (word_d_reg >> 19) ^ t ^ (t >> 8);

    assign status.all_zero = ((word_a_reg | word_b_reg | word_c_reg
                               | (mixed ^ xs128_pkg::SEED_XOR_D)) == 32'd0);
    assign random_word     = out_reg;

    always_comb begin
        word_a_next = word_a_reg;
        word_b_next = word_b_reg;
        word_c_next = word_c_reg;
        word_d_next = word_d_reg;
        seed_next   = seed_reg;
        prod_next   = prod_reg;
        out_next    = out_reg;
        if (cmd.load_seed) begin
            seed_next = seed_in;
        end
        if (cmd.mul) begin
            prod_next = seed_reg * xs128_pkg::SEED_MULT + 32'd1;
        end
        if (cmd.mix) begin
            seed_next = mixed;
            case (cmd.word_sel)
                xs128_pkg::WORD_A: word_a_next = loaded;
                xs128_pkg::WORD_B: word_b_next = loaded;
                xs128_pkg::WORD_C: word_c_next = loaded;
                xs128_pkg::WORD_D: word_d_next = loaded;
                default:           word_a_next = word_a_reg;
            endcase
        end
        if (cmd.load_reset) begin
            word_a_next = xs128_pkg::RESET_A;
            word_b_next = xs128_pkg::RESET_B;
            word_c_next = xs128_pkg::RESET_C;
            word_d_next = xs128_pkg::RESET_D;
        end
        if (cmd.advance) begin
            word_a_next = word_b_reg;
            word_b_next = word_c_reg;
            word_c_next = word_d_reg;
            word_d_next = step_d;
            out_next    = step_d;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_a_reg <= xs128_pkg::RESET_A;
            word_b_reg <= xs128_pkg::RESET_B;
            word_c_reg <= xs128_pkg::RESET_C;
            word_d_reg <= xs128_pkg::RESET_D;
        end else begin
            word_a_reg <= word_a_next;
            word_b_reg <= word_b_next;
            word_c_reg <= word_c_next;
            word_d_reg <= word_d_next;
        end
    end

    always_ff @(posedge aclk) begin
        seed_reg <= seed_next;
        prod_reg <= prod_next;
        out_reg  <= out_next;
    end

endmodule

// ----- hdl/xs128_ctrl.sv -----
// Controller: handshakes, seeding sequence and output valid.
module xs128_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_op,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  xs128_pkg::dp_status_t status,
    output xs128_pkg::dp_cmd_t    cmd
);

    xs128_pkg::state_t state_reg, state_next;
    xs128_pkg::word_sel_t round_reg, round_next;
    logic [xs128_pkg::PASS_W-1:0] pass_reg, pass_next;
    logic m_valid_reg, m_valid_next;
    logic accept;

    assign s_ready = (state_reg == xs128_pkg::ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        round_next   = round_reg;
        pass_next    = pass_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        cmd.word_sel = round_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            xs128_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_op == xs128_pkg::OP_NEXT) begin
                        cmd.advance  = 1'b1;
                        m_valid_next = 1'b1;
                    end else begin
                        cmd.load_seed = 1'b1;
                        round_next    = xs128_pkg::WORD_A;
                        pass_next     = '0;
                        state_next    = xs128_pkg::ST_MUL;
                    end
                end
            end
            xs128_pkg::ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = xs128_pkg::ST_MIX;
            end
            xs128_pkg::ST_MIX: begin
                cmd.mix    = 1'b1;
                state_next = xs128_pkg::ST_MUL;
                round_next = xs128_pkg::word_sel_t'(round_reg + 2'd1);
                if (round_reg == xs128_pkg::WORD_D) begin
                    if (!status.all_zero) begin
                        state_next = xs128_pkg::ST_IDLE;
                    end else if (pass_reg == xs128_pkg::PASS_W'(xs128_pkg::SEED_PASSES - 1)) begin
                        cmd.load_reset = 1'b1;
                        state_next     = xs128_pkg::ST_IDLE;
                    end else begin
                        pass_next = pass_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = xs128_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= xs128_pkg::ST_IDLE;
            round_reg   <= xs128_pkg::WORD_A;
            pass_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            round_reg   <= round_next;
            pass_reg    <= pass_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- verif/tb_top.sv -----
// Testbench for the xorshift128 generator: directed and random seed/next items with self-check.
module tb_top;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_op;
    logic [31:0] s_seed_value;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_random_word;

    logic [31:0] xs_x, xs_y, xs_z, xs_w;
    logic [31:0] pending_words[$];
    int unsigned error_count;
    bit          sender_idles;
    bit          receiver_idles;

    xorshift128_generator_with_seeding_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_seed_value  (s_seed_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_random_word (m_random_word)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [31:0] scramble_seed(input logic [31:0] s);
        logic [31:0] v;
        v = s * xs128_pkg::SEED_MULT + 32'd1;
        v = v ^ (v << 13);
        v = v ^ (v >> 17);
        return v;
    endfunction

    task automatic reseed_words(input logic [31:0] seed);
        logic [31:0] s;
        s = seed;
        for (int unsigned pass = 0; pass < xs128_pkg::SEED_PASSES; pass++) begin
            s = scramble_seed(s);
            xs_x = xs128_pkg::SEED_XOR_A ^ s;
            s = scramble_seed(s);
            xs_y = xs128_pkg::SEED_XOR_B ^ s;
            s = scramble_seed(s);
            xs_z = xs128_pkg::SEED_XOR_C ^ s;
            s = scramble_seed(s);
            xs_w = xs128_pkg::SEED_XOR_D ^ s;
            if ((xs_x | xs_y | xs_z | xs_w) != 32'd0) return;
        end
        xs_x = xs128_pkg::RESET_A;
        xs_y = xs128_pkg::RESET_B;
        xs_z = xs128_pkg::RESET_C;
        xs_w = xs128_pkg::RESET_D;
    endtask

    task automatic next_word();
        logic [31:0] t;
        t = xs_x ^ (xs_x << 11);
        xs_x = xs_y;
        xs_y = xs_z;
        xs_z = xs_w;
        xs_w = xs_w ^ (xs_w >> 19) ^ t ^ (t >> 8);
        pending_words.push_back(xs_w);
    endtask

    task automatic send_item(input logic op, input logic [31:0] seed);
        int unsigned gap;
        gap = sender_idles ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_op         <= op;
        s_seed_value <= seed;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (op == xs128_pkg::OP_SEED) begin
            reseed_words(seed);
        end else begin
            next_word();
        end
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(negedge aclk);
    endtask

    task automatic test_reset_words();
        repeat (5) send_item(xs128_pkg::OP_NEXT, $urandom);
    endtask

    task automatic test_seed_extremes();
        logic [31:0] seeds[4];
        seeds = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0001, 32'h5555_AAAA};
        foreach (seeds[i]) begin
            send_item(xs128_pkg::OP_SEED, seeds[i]);
            send_item(xs128_pkg::OP_NEXT, ~seeds[i]);
            send_item(xs128_pkg::OP_NEXT, seeds[i]);
        end
    endtask

    task automatic test_back_to_back_seeds();
        send_item(xs128_pkg::OP_SEED, 32'hAAAA_5555);
        send_item(xs128_pkg::OP_SEED, 32'h0000_0001);
        send_item(xs128_pkg::OP_NEXT, 32'hFFFF_FFFF);
        wait_drained();
        sender_idles = 1'b0;
        send_item(xs128_pkg::OP_SEED, 32'h7FFF_FFFF);
        send_item(xs128_pkg::OP_NEXT, 32'h0);
        send_item(xs128_pkg::OP_NEXT, 32'h0);
        sender_idles = 1'b1;
    endtask

    task automatic test_random_items();
        logic [31:0] seed;
        for (int n = 0; n < 750; n++) begin
            if (n % 60 == 0) begin
                sender_idles   = ($urandom_range(0, 3) != 0);
                receiver_idles = ($urandom_range(0, 3) != 0);
            end
            if (n == 400) wait_drained();
            case ($urandom_range(0, 7))
                0: seed = 32'h0;
                1: seed = 32'hFFFF_FFFF;
                default: seed = $urandom;
            endcase
            send_item(($urandom_range(0, 6) == 0) ? xs128_pkg::OP_SEED : xs128_pkg::OP_NEXT,
                      seed);
        end
        s_valid <= 1'b0;
    endtask

    initial begin : result_checker
        logic [31:0] want;
        int unsigned stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            stall = receiver_idles ? $urandom_range(0, 3) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            if (pending_words.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual %08h",
                         $time, m_random_word);
            end else begin
                want = pending_words.pop_front();
                if (m_random_word !== want) begin
                    error_count++;
                    $display("%0t: random_word mismatch, expected %08h, actual %08h",
                             $time, want, m_random_word);
                end
            end
            @(negedge aclk);
        end
    end

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_op           = xs128_pkg::OP_NEXT;
        s_seed_value   = 32'd0;
        error_count    = 0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        xs_x = xs128_pkg::RESET_A;
        xs_y = xs128_pkg::RESET_B;
        xs_z = xs128_pkg::RESET_C;
        xs_w = xs128_pkg::RESET_D;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_words();
        test_seed_extremes();
        test_back_to_back_seeds();
        test_random_items();

        wait_drained();
        repeat (100) @(negedge aclk);
        if (pending_words.size() != 0) begin
            error_count++;
            $display("%0t: missing result, expected %08h, actual none",
                     $time, pending_words[0]);
        end
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
